// ===== src/irwq_pkg.sv =====
// Shared types and constants for the I2C register write queue.
// Used by every module of the block but the checker; depends on nothing else.
package irwq_pkg;

  localparam int QueueDepthDefault = 16;
  localparam logic [6:0] DevAddrReset = 7'd28;

  typedef enum logic [1:0] {
    REQ_WRITE      = 2'd0,
    REQ_BYTE_SENT  = 2'd1,
    REQ_CLEAR      = 2'd2,
    REQ_HARD_CLEAR = 2'd3
  } req_t;

  // Classified command handed from the front end to the sequencer.
  typedef struct packed {
    req_t        req;
    logic [15:0] word;
    logic        first;
    logic [7:0]  count;
    logic        err;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    logic       start_tx;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       stop_bus;
    logic       bus_reset;
    logic       refresh_request;
    logic       busy_res;
    logic [6:0] target_addr;
  } res_t;

endpackage

// ===== src/irwq_front.sv =====
// Front end: accepts request items, classifies them and holds them in a
// two-entry command queue. Depends on irwq_pkg.
module irwq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    req_type,
  input  logic [7:0]    reg_addr,
  input  logic [7:0]    reg_value,
  input  logic          batch_first,
  input  logic [7:0]    batch_count,
  input  logic          bus_error,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output irwq_pkg::cmd_t cmd
);
  import irwq_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       classified;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    classified.req   = req_t'(req_type);
    classified.word  = {reg_addr, reg_value};
    classified.first = batch_first;
    // A zero count is taken as a batch of one word.
    classified.count = (batch_count == 8'd0) ? 8'd1 : batch_count;
    classified.err   = bus_error;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entry[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/irwq_back.sv =====
// Back end: the transfer sequencer with the word store, its pointers and
// the device address register. Depends on irwq_pkg.
module irwq_back #(
  parameter int QUEUE_DEPTH = irwq_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_take,
  input  irwq_pkg::cmd_t cmd,
  input  logic           res_full,
  output logic           res_push,
  output irwq_pkg::res_t res,
  input  logic           cfg_valid,
  input  logic [6:0]     cfg_data
);
  import irwq_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int CmpW = ((CntW > 8) ? CntW : 8) + 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  logic [15:0]     mem [QUEUE_DEPTH];
  logic [15:0]     rd_data;

  state_t          state, state_next;
  cmd_t            cur_cmd;
  logic [PtrW-1:0] rd_ptr, rd_ptr_next;
  logic [PtrW-1:0] wr_ptr, wr_ptr_next;
  logic [CntW-1:0] fill, fill_next;
  logic [15:0]     cur_word, cur_word_next;
  logic            low_sent, low_sent_next;
  logic            active, active_next;
  logic            rejected, rejected_next;
  logic [6:0]      dev_addr;

  logic [CntW-1:0] room;
  logic [CmpW-1:0] room_ext;
  logic [CmpW-1:0] cnt_ext;
  logic            mem_we;
  res_t            r;

  assign room     = DepthCnt - fill;
  assign room_ext = CmpW'(room);
  assign cnt_ext  = CmpW'(cur_cmd.count);

  assign cmd_take = (state == ST_IDLE) && cmd_valid && !res_full;
  assign res_push = (state == ST_EXEC);
  assign res      = r;

  always_comb begin
    state_next    = state;
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    fill_next     = fill;
    cur_word_next = cur_word;
    low_sent_next = low_sent;
    active_next   = active;
    rejected_next = rejected;
    mem_we        = 1'b0;
    r             = '0;

    case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (cur_cmd.req)
          REQ_WRITE: begin
            if (cur_cmd.first) begin
              if (!active) begin
                // Idle: the first word goes straight out, so one entry less is needed.
                if (cnt_ext - CmpW'(1) > room_ext) begin
                  rejected_next = 1'b1;
                end else begin
                  rejected_next = 1'b0;
                  cur_word_next = cur_cmd.word;
                  low_sent_next = 1'b0;
                  active_next   = 1'b1;
                  r.start_tx    = 1'b1;
                  r.tx_valid    = 1'b1;
                  r.tx_byte     = cur_cmd.word[15:8];
                  r.accepted    = 1'b1;
                end
              end else if (cnt_ext > room_ext) begin
                rejected_next = 1'b1;
              end else begin
                rejected_next = 1'b0;
                mem_we        = (fill != DepthCnt);
              end
            end else if (!rejected) begin
              mem_we = (fill != DepthCnt);
            end
            if (mem_we) begin
              r.accepted  = 1'b1;
              wr_ptr_next = (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
              fill_next   = fill + CntW'(1);
            end
          end
          REQ_BYTE_SENT: begin
            if (active) begin
              if (cur_cmd.err) begin
                rd_ptr_next       = '0;
                wr_ptr_next       = '0;
                fill_next         = '0;
                active_next       = 1'b0;
                r.stop_bus        = 1'b1;
                r.bus_reset       = 1'b1;
                r.refresh_request = 1'b1;
              end else if (!low_sent) begin
                low_sent_next = 1'b1;
                r.tx_valid    = 1'b1;
                r.tx_byte     = cur_word[7:0];
                r.stop_bus    = 1'b1;
              end else if (fill != '0) begin
                cur_word_next = rd_data;
                low_sent_next = 1'b0;
                rd_ptr_next   = (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
                fill_next     = fill - CntW'(1);
                r.start_tx    = 1'b1;
                r.tx_valid    = 1'b1;
                r.tx_byte     = rd_data[15:8];
              end else begin
                r.stop_bus  = 1'b1;
                active_next = 1'b0;
              end
            end
          end
          REQ_CLEAR: begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
          end
          REQ_HARD_CLEAR: begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
            active_next = 1'b0;
            r.stop_bus  = 1'b1;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
        r.busy_res    = active_next;
        r.target_addr = r.start_tx ? dev_addr : 7'd0;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The head entry is read every cycle; the value read while idle is the
  // one used when the item executes, as the read pointer does not move
  // in between.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_ptr];
    if (mem_we) begin
      mem[wr_ptr] <= cur_cmd.word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur_cmd <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      fill     <= '0;
      cur_word <= '0;
      low_sent <= 1'b0;
      active   <= 1'b0;
      rejected <= 1'b0;
      dev_addr <= DevAddrReset;
    end else begin
      state    <= state_next;
      rd_ptr   <= rd_ptr_next;
      wr_ptr   <= wr_ptr_next;
      fill     <= fill_next;
      cur_word <= cur_word_next;
      low_sent <= low_sent_next;
      active   <= active_next;
      rejected <= rejected_next;
      if (cfg_valid) begin
        dev_addr <= cfg_data;
      end
    end
  end

endmodule

// ===== src/irwq_res_fifo.sv =====
// Two-entry result queue that separates the sequencer from the consumer.
// Depends on irwq_pkg.
module irwq_res_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  output logic           full,
  input  irwq_pkg::res_t wr_data,
  input  logic           pop,
  output logic           empty,
  output irwq_pkg::res_t rd_data
);
  import irwq_pkg::*;

  res_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = entry[rd_ptr];
  assign do_push = wr_en && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/i2c_register_write_queue.sv =====
// I2C register write queue: every request item gives exactly one result item.
// A taken item is latched by the sequencer, executed, and its result registered in
// the result queue. No new item is taken until the last has executed, that is, the
// word store head has been read (registered read) and the item executed.
// Reset (rst, synchronous): both queues empty, idle, device address 28.
// The word store needs no clearing; only written entries are ever used.
module i2c_register_write_queue #(
  parameter int QUEUE_DEPTH = irwq_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type,
  input  logic [7:0] reg_addr,
  input  logic [7:0] reg_value,
  input  logic       batch_first,
  input  logic [7:0] batch_count,
  input  logic       bus_error,
  output logic       empty,
  input  logic       pop,
  output logic       accepted,
  output logic       start_tx,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       stop_bus,
  output logic       bus_reset,
  output logic       refresh_request,
  output logic       busy_res,
  output logic [6:0] target_addr,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);
  import irwq_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_out;

  assign cfg_ready = 1'b1;

  irwq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .reg_addr    (reg_addr),
    .reg_value   (reg_value),
    .batch_first (batch_first),
    .batch_count (batch_count),
    .bus_error   (bus_error),
    .cmd_valid   (cmd_valid),
    .cmd_take    (cmd_take),
    .cmd         (cmd)
  );

  irwq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

  irwq_res_fifo u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .full    (res_full),
    .wr_data (res_in),
    .pop     (pop),
    .empty   (empty),
    .rd_data (res_out)
  );

  assign accepted        = res_out.accepted;
  assign start_tx        = res_out.start_tx;
  assign tx_valid        = res_out.tx_valid;
  assign tx_byte         = res_out.tx_byte;
  assign stop_bus        = res_out.stop_bus;
  assign bus_reset       = res_out.bus_reset;
  assign refresh_request = res_out.refresh_request;
  assign busy_res        = res_out.busy_res;
  assign target_addr     = res_out.target_addr;

endmodule

// ===== src/irwq_checker.sv =====
// Port-level checks for the I2C register write queue, bound to the top level.
// Depends only on the top level's ports.
module irwq_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       start_tx,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       stop_bus,
  input logic       bus_reset,
  input logic       refresh_request,
  input logic       busy_res,
  input logic [6:0] target_addr
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // A start always comes with a byte and leaves a transfer running.
  a_start_has_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && start_tx) |-> (tx_valid && busy_res))
    else $error("start without byte or without busy");

  // Bus recovery ends the transfer and asks for a stop and a refresh.
  a_bus_reset: assert property (@(posedge clk) disable iff (rst)
    (!empty && bus_reset) |-> (stop_bus && refresh_request && !busy_res && !tx_valid))
    else $error("bus recovery result inconsistent");

  // Idle byte and address lanes read as zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !tx_valid) |-> (tx_byte == 8'd0 && target_addr == 7'd0))
    else $error("byte or address set without a byte");

endmodule

bind i2c_register_write_queue irwq_checker u_irwq_checker (
  .clk             (clk),
  .rst             (rst),
  .empty           (empty),
  .start_tx        (start_tx),
  .tx_valid        (tx_valid),
  .tx_byte         (tx_byte),
  .stop_bus        (stop_bus),
  .bus_reset       (bus_reset),
  .refresh_request (refresh_request),
  .busy_res        (busy_res),
  .target_addr     (target_addr)
);
